// ===== rtl/vertex_matrix_transform_assert.svh =====
// Assertion macros for the vertex matrix transform block.
`ifndef VERTEX_MATRIX_TRANSFORM_ASSERT_SVH
`define VERTEX_MATRIX_TRANSFORM_ASSERT_SVH
`ifndef SYNTH
`define VMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vmt assertion failed");
`define VMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vmt assertion failed");
`else
`define VMT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/vmt_pkg.sv =====
// Shared types and constants for the vertex matrix transform block.
`default_nettype none
package vmt_pkg;

	// Arithmetic widths
	localparam int COEF_WIDTH  = 16;
	localparam int COORD_WIDTH = 16;
	localparam int FIELD_W     = 16;
	localparam int SLOT_W      = 16;
	localparam int NCOL        = 4;
	localparam int NLANE       = 4;
	localparam int ROW_W       = NCOL * SLOT_W;
	localparam int CW_EFF      = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
	localparam int COEF_FRAC   = COEF_WIDTH - 4;
	localparam int PROD_W      = COEF_WIDTH + CW_EFF;
	localparam int SUM_W       = PROD_W + 2;

	// Configuration port
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_AFFINE = 3'd4
	} cfg_reg_t;

	// Identity matrix at reset
	localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
	localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] in_x;
		logic signed [FIELD_W-1:0] in_y;
		logic signed [FIELD_W-1:0] in_z;
		logic signed [FIELD_W-1:0] in_w;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [FIELD_W-1:0] out_w;
		logic                      clipped;
	} out_item_t;

	// Pipeline control seen by the merge stage
	typedef struct packed {
		logic adv;
		logic valid_s2;
	} pipe_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/vertex_matrix_transform.sv =====
// Top level: 4x4 fixed-point matrix times vertex, four row lanes and a merge stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  vtx     | in        | vtx_valid, vtx_stall | in_item_t  (x, y, z, w Q8.8)
//  res     | out       | res_valid, res_stall | out_item_t (x, y, z, w, clip)
//  apb     | in        | psel, penable, pwrite| 64-bit rows at 8*i, affine at 32
//
// One item per cycle unless res_stall holds the result register; the stages
// are lane multiply, lane sum and saturate, merge register. A one-item skid
// buffer at the input takes the item arriving while the result register is
// stalled, so vtx_stall is a register. Reset loads the identity matrix, clears
// affine mode and empties the pipeline.
`default_nettype none
module vertex_matrix_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vtx_valid,
	output logic                          vtx_stall,
	input  vmt_pkg::in_item_t             vtx,
	output logic                          res_valid,
	input  logic                          res_stall,
	output vmt_pkg::out_item_t            res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vmt_pkg::ADDR_W-1:0]    paddr,
	input  logic [vmt_pkg::DATA_W-1:0]    pwdata,
	output logic [vmt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import vmt_pkg::*;
	`include "vertex_matrix_transform_assert.svh"

	logic [ROW_W-1:0] row_q [NLANE];
	logic             affine_q;
	cfg_reg_t         reg_sel;
	logic             cfg_wr;

	in_item_t                  skid_q;
	logic                      skid_valid_q;
	in_item_t                  src;
	logic                      src_valid;
	logic                      adv;
	logic                      valid_s1;
	logic                      valid_s2;
	logic signed [CW_EFF-1:0]  w_src;
	logic signed [FIELD_W-1:0] w_s1;
	logic signed [FIELD_W-1:0] w_s2;
	logic signed [FIELD_W-1:0] lane_value [NLANE];
	logic                      lane_clip  [NLANE];
	pipe_ctl_t                 ctl;

	// Register file
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[ADDR_W-1:3]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			row_q[3] <= ROW3_RST;
			affine_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_ROW0:   row_q[0] <= pwdata;
				REG_ROW1:   row_q[1] <= pwdata;
				REG_ROW2:   row_q[2] <= pwdata;
				REG_ROW3:   row_q[3] <= pwdata;
				REG_AFFINE: affine_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ROW0:   prdata = row_q[0];
			REG_ROW1:   prdata = row_q[1];
			REG_ROW2:   prdata = row_q[2];
			REG_ROW3:   prdata = row_q[3];
			REG_AFFINE: prdata = DATA_W'(affine_q);
			default:    prdata = '0;
		endcase
	end

	// Advance whenever the result register is free or being taken
	assign adv       = ~(res_valid & res_stall);
	assign vtx_stall = skid_valid_q;
	assign src       = skid_valid_q ? skid_q : vtx;
	assign src_valid = skid_valid_q | vtx_valid;

	// Skid buffer: park an item accepted while the pipeline holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			skid_valid_q <= 1'b0;
		end else if (vtx_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && vtx_valid && !skid_valid_q) begin
			skid_q <= vtx;
		end
	end

	// Valid chain through the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Carry input w for affine pass-through
	assign w_src = src.in_w[CW_EFF-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= FIELD_W'(w_src);
			w_s2 <= w_s1;
		end
	end

	// One lane per matrix row
	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		vmt_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.row      (row_q[l]),
			.vtx      (src),
			.value_s2 (lane_value[l]),
			.clip_s2  (lane_clip[l])
		);
	end

	assign ctl.adv      = adv;
	assign ctl.valid_s2 = valid_s2;

	vmt_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.lane_value (lane_value),
		.lane_clip  (lane_clip),
		.affine     (affine_q),
		.w_s2       (w_s2),
		.res        (res),
		.res_valid  (res_valid)
	);

	// Checks on the item flow
	`VMT_ASSERT_NEXT(a_skid_hold, clk, arst_n, skid_valid_q && !adv, skid_valid_q && $stable(skid_q))
	`VMT_ASSERT_NEXT(a_s1_to_s2, clk, arst_n, adv && valid_s1, valid_s2)
	`VMT_ASSERT_NEXT(a_s2_to_res, clk, arst_n, adv && valid_s2, res_valid)

endmodule
`default_nettype wire

// ===== rtl/vmt_lane.sv =====
// One matrix row dot product: multiply stage, then sum, floor shift and saturate.
`default_nettype none
module vmt_lane (
	input  logic                             clk,
	input  logic                             en,
	input  logic [vmt_pkg::ROW_W-1:0]        row,
	input  vmt_pkg::in_item_t                vtx,
	output logic signed [vmt_pkg::FIELD_W-1:0] value_s2,
	output logic                             clip_s2
);
	import vmt_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (CW_EFF - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	logic        [FIELD_W-1:0]    fld     [NCOL];
	logic signed [COEF_WIDTH-1:0] coef    [NCOL];
	logic signed [CW_EFF-1:0]     crd     [NCOL];
	logic signed [PROD_W-1:0]     prod_s1 [NCOL];
	logic signed [SUM_W-1:0]      sum;
	logic signed [SUM_W-1:0]      shifted;
	logic signed [SUM_W-1:0]      sat;
	logic                         clip;

	assign fld[0] = vtx.in_x;
	assign fld[1] = vtx.in_y;
	assign fld[2] = vtx.in_z;
	assign fld[3] = vtx.in_w;

	// Slice coefficients and coordinates to their effective widths
	always_comb begin
		for (int c = 0; c < NCOL; c++) begin
			coef[c] = row[c*SLOT_W +: COEF_WIDTH];
			crd[c]  = fld[c][CW_EFF-1:0];
		end
	end

	// Multiply each column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOL; c++) begin
				prod_s1[c] <= coef[c] * crd[c];
			end
		end
	end

	// Sum, floor the fraction away and clamp
	always_comb begin
		sum = '0;
		for (int c = 0; c < NCOL; c++) begin
			sum = sum + SUM_W'(prod_s1[c]);
		end
		shifted = sum >>> COEF_FRAC;
		clip    = 1'b0;
		sat     = shifted;
		if (shifted > SAT_HI) begin
			sat  = SAT_HI;
			clip = 1'b1;
		end else if (shifted < SAT_LO) begin
			sat  = SAT_LO;
			clip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s2 <= FIELD_W'(sat);
			clip_s2  <= clip;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/vmt_merge.sv =====
// Merge of the four row lanes into the registered result item.
`default_nettype none
module vmt_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vmt_pkg::pipe_ctl_t                 ctl,
	input  logic signed [vmt_pkg::FIELD_W-1:0] lane_value [vmt_pkg::NLANE],
	input  logic                               lane_clip  [vmt_pkg::NLANE],
	input  logic                               affine,
	input  logic signed [vmt_pkg::FIELD_W-1:0] w_s2,
	output vmt_pkg::out_item_t                 res,
	output logic                               res_valid
);
	import vmt_pkg::*;

	out_item_t merged;
	out_item_t res_q;
	logic      res_valid_q;

	// Pick w and combine the clip flags
	always_comb begin
		merged.out_x   = lane_value[0];
		merged.out_y   = lane_value[1];
		merged.out_z   = lane_value[2];
		merged.out_w   = affine ? w_s2 : lane_value[3];
		merged.clipped = lane_clip[0] | lane_clip[1] | lane_clip[2] |
			(lane_clip[3] & ~affine);
	end

	// Hold the result item until taken
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			res_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.adv) begin
			res_valid_q <= ctl.valid_s2;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule
`default_nettype wire
